@@ design/annealing_tour_swap_step_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the annealing tour swap step core
// Shared property wrappers; clk_i and rst_ni are taken from the using module.
// ----------------------------------------------------------------------------
`ifndef ANNEALING_TOUR_SWAP_STEP_CORE_DEFINES_SVH
`define ANNEALING_TOUR_SWAP_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define ATSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/atss_pkg.sv @@
// ----------------------------------------------------------------------------
// atss_pkg
// Shared types, codes and constants of the annealing tour swap step core.
// ----------------------------------------------------------------------------
package atss_pkg;

  // default sizes
  localparam int unsigned CITY_COUNT_DEF    = 8;
  localparam int unsigned DISTANCE_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned COST_W   = 19;
  localparam int unsigned TEMP_W   = 32;
  localparam int unsigned COOL_W   = 16;
  localparam int unsigned DRAW_W   = 16;
  localparam int unsigned DIST_IN_W = 16;
  localparam int unsigned FIELD_CITY_W = 3;
  localparam int unsigned ORDER_POS = 8;
  localparam int unsigned ORDER_W  = ORDER_POS * FIELD_CITY_W;
  localparam int unsigned PROD_W   = TEMP_W + DRAW_W;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // stream and config widths
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // command codes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2
  } atss_op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_TEMP = 2'd0,
    CFG_COOLING   = 2'd1,
    CFG_STOP_TEMP = 2'd2
  } atss_cfg_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic trial_ident;
    logic swap_a;
    logic swap_b;
    logic cost_clr;
    logic cost_issue;
    logic mul_draw;
    logic decide;
    logic start_set;
    logic best_upd;
    logic out_load;
  } atss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       hot;
    logic       out_busy;
  } atss_stat_t;

endpackage

@@ design/annealing_tour_swap_step_core.sv @@
// ----------------------------------------------------------------------------
// annealing_tour_swap_step_core
// Simulated-annealing engine for a closed tour over CITY_COUNT cities.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_axis channel; tuser carries the command (load a
//   distance entry, start a run, annealing step). Every item yields exactly
//   one result item on m_axis: accepted flag, current cost, best cost, the
//   best tour (first eight positions) and the finished flag.
//   Configuration (initial temperature, cooling factor, stop temperature)
//   is written on the cfg channel, which is always ready; write it only
//   while no item is in flight.
//   A start and a running step work out the whole tour cost; a load, an
//   unused command and a step once cooled do not. The tour cost reads one
//   distance per cycle from a single-port memory. The next item is
//   accepted once the result is registered. One item is worked on at a
//   time.
//   A result waits in the output register while m_axis_tready is low; a
//   following item is still accepted and worked on, and holds only at its
//   own result until the register frees. Reset restores the configuration
//   defaults, identity tours, zero costs and zero temperature; the distance
//   memory is not cleared.
module annealing_tour_swap_step_core #(
  parameter int unsigned CITY_COUNT    = atss_pkg::CITY_COUNT_DEF,
  parameter int unsigned DISTANCE_BITS = atss_pkg::DISTANCE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // from_city, to_city, distance_value, swap_first, swap_second, log_draw
  input  logic [atss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic [atss_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  // result out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // accepted, current_cost, best_cost, best_order, finished
  output logic [atss_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [atss_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [atss_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import atss_pkg::*;

  atss_cmd_t  cmd;
  atss_stat_t stat;

  // sequencer
  atss_ctrl #(
    .CITY_COUNT (CITY_COUNT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // storage and arithmetic
  atss_datapath #(
    .CITY_COUNT    (CITY_COUNT),
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

  assign cfg_ready_o = 1'b1;

endmodule

@@ design/atss_ctrl.sv @@
// ----------------------------------------------------------------------------
// atss_ctrl
// Sequencer: decodes each item and steps the datapath through load, start
// and annealing step, one item at a time.
// ----------------------------------------------------------------------------
module atss_ctrl #(
  parameter int unsigned CITY_COUNT = atss_pkg::CITY_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  atss_pkg::atss_stat_t  stat_i,
  output atss_pkg::atss_cmd_t   cmd_o
);
  import atss_pkg::*;

  localparam int unsigned CW = (CITY_COUNT > 1) ? $clog2(CITY_COUNT) : 1;
  localparam logic [CW-1:0] LAST = CW'(CITY_COUNT - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SWAP_B,
    ST_COST,
    ST_COST_TAIL,
    ST_START_SET,
    ST_DECIDE,
    ST_BEST,
    ST_FINISH
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = s_axis_tvalid;
        if (s_axis_tvalid) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cnt_d = '0;
        case (stat_i.op)
          OP_LOAD: begin
            cmd_o.load_wr = 1'b1;
            state_d       = ST_FINISH;
          end
          OP_START: begin
            cmd_o.trial_ident = 1'b1;
            cmd_o.cost_clr    = 1'b1;
            state_d           = ST_COST;
          end
          OP_STEP: begin
            if (stat_i.hot) begin
              cmd_o.swap_a = 1'b1;
              state_d      = ST_SWAP_B;
            end else begin
              state_d = ST_FINISH;
            end
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_SWAP_B: begin
        cmd_o.swap_b   = 1'b1;
        cmd_o.cost_clr = 1'b1;
        state_d        = ST_COST;
      end
      // one distance read per tour edge
      ST_COST: begin
        cmd_o.cost_issue = 1'b1;
        cnt_d            = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = ST_COST_TAIL;
        end
      end
      ST_COST_TAIL: begin
        cmd_o.mul_draw = 1'b1;
        state_d = (stat_i.op == OP_START) ? ST_START_SET : ST_DECIDE;
      end
      ST_START_SET: begin
        cmd_o.start_set = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_BEST;
      end
      ST_BEST: begin
        cmd_o.best_upd = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

endmodule

@@ design/atss_datapath.sv @@
// ----------------------------------------------------------------------------
// atss_datapath
// Distance memory, tour registers, cost accumulator, shared multiplier,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`include "annealing_tour_swap_step_core_defines.svh"

module atss_datapath #(
  parameter int unsigned CITY_COUNT    = atss_pkg::CITY_COUNT_DEF,
  parameter int unsigned DISTANCE_BITS = atss_pkg::DISTANCE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item fields
  input  logic [atss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [atss_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  // result channel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [atss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // configuration writes
  input  logic                                cfg_valid_i,
  input  logic [atss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [atss_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // sequencer link
  input  atss_pkg::atss_cmd_t                 cmd_i,
  output atss_pkg::atss_stat_t                stat_o
);
  import atss_pkg::*;

  localparam int unsigned CW    = (CITY_COUNT > 1) ? $clog2(CITY_COUNT) : 1;
  localparam int unsigned AW    = 2 * CW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned SUMW  = ((DISTANCE_BITS > COST_W) ? DISTANCE_BITS : COST_W) + 1;
  localparam logic [5:0]  N1    = 6'(CITY_COUNT);
  localparam logic [5:0]  N2    = 6'(2 * CITY_COUNT);

  // configuration
  logic [TEMP_W-1:0] init_temp_q, stop_temp_q;
  logic [COOL_W-1:0] cooling_q;

  // captured item
  logic [1:0]              op_q;
  logic [FIELD_CITY_W-1:0] from_q, to_q;
  logic [DIST_IN_W-1:0]    dist_q;
  logic [DRAW_W-1:0]       draw_q;
  logic [CW-1:0]           pos_p_q, pos_q_q;
  logic [CW-1:0]           pos_p_d, pos_q_d;

  // tours
  logic [CW-1:0] trial_q [CITY_COUNT];
  logic [CW-1:0] trial_d [CITY_COUNT];
  logic [CW-1:0] cur_q   [CITY_COUNT];
  logic [CW-1:0] best_q  [CITY_COUNT];
  logic [CW-1:0] tmp_q;

  // costs and temperature
  logic [COST_W-1:0] acc_q, cur_total_q, best_total_q;
  logic [TEMP_W-1:0] temp_q;
  logic [PROD_W-1:0] prod_q;
  logic              accepted_q;

  // distance memory
  logic [DISTANCE_BITS-1:0] mem [DEPTH];
  logic [DISTANCE_BITS-1:0] rdata_q;
  logic                     rd_vld_q;
  logic [AW-1:0]            waddr, raddr;
  logic                     load_ok;

  // datapath helpers
  logic [SUMW-1:0]    sum;
  logic [COST_W-1:0]  rise;
  logic               accept_w;
  logic [ORDER_W-1:0] order_w;

  // result register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  // swap positions reduced into the city range (value below three times N)
  always_comb begin
    logic [5:0] p6, q6;
    p6 = 6'(s_axis_tdata[24:22]);
    q6 = 6'(s_axis_tdata[27:25]);
    if (p6 >= N2) p6 = p6 - N2;
    else if (p6 >= N1) p6 = p6 - N1;
    if (q6 >= N2) q6 = q6 - N2;
    else if (q6 >= N1) q6 = q6 - N1;
    pos_p_d = CW'(p6);
    pos_q_d = CW'(q6);
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= s_axis_tuser;
      from_q  <= s_axis_tdata[2:0];
      to_q    <= s_axis_tdata[5:3];
      dist_q  <= s_axis_tdata[21:6];
      pos_p_q <= pos_p_d;
      pos_q_q <= pos_q_d;
      draw_q  <= s_axis_tdata[43:28];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_temp_q <= 32'd655360000;
      cooling_q   <= 16'd65470;
      stop_temp_q <= 32'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INIT_TEMP: init_temp_q <= cfg_data_i;
        CFG_COOLING:   cooling_q   <= cfg_data_i[COOL_W-1:0];
        CFG_STOP_TEMP: stop_temp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // distance memory: one write or one read per cycle
  assign load_ok = (32'(from_q) < CITY_COUNT) && (32'(to_q) < CITY_COUNT);
  assign waddr   = {CW'(from_q), CW'(to_q)};
  assign raddr   = {trial_q[0], trial_q[(CITY_COUNT > 1) ? 1 : 0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && load_ok) begin
      mem[waddr] <= DISTANCE_BITS'(dist_q);
    end
    if (cmd_i.cost_issue) begin
      rdata_q <= mem[raddr];
    end
  end

  // trial tour: identity, swap from current, or rotate while costing
  always_comb begin
    for (int i = 0; i < CITY_COUNT; i++) begin
      trial_d[i] = trial_q[i];
      if (cmd_i.trial_ident) begin
        trial_d[i] = CW'(i);
      end else if (cmd_i.swap_b) begin
        if (CW'(i) == pos_p_q) trial_d[i] = cur_q[pos_q_q];
        else if (CW'(i) == pos_q_q) trial_d[i] = tmp_q;
        else trial_d[i] = cur_q[i];
      end else if (cmd_i.cost_issue) begin
        trial_d[i] = trial_q[(i == CITY_COUNT - 1) ? 0 : i + 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    trial_q <= trial_d;
    if (cmd_i.swap_a) begin
      tmp_q <= cur_q[pos_p_q];
    end
  end

  // saturating cost accumulator, one entry behind the read
  assign sum = SUMW'(acc_q) + SUMW'(rdata_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.cost_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cost_clr) begin
      acc_q <= '0;
    end else if (rd_vld_q) begin
      acc_q <= (sum > SUMW'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
    end
  end

  // shared multiplier: temperature times draw, then times cooling factor
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_draw) begin
      prod_q <= PROD_W'(temp_q) * PROD_W'(draw_q);
    end else if (cmd_i.decide) begin
      prod_q <= PROD_W'(temp_q) * PROD_W'(cooling_q);
    end
  end

  // Metropolis test
  assign rise     = acc_q - cur_total_q;
  assign accept_w = (acc_q <= cur_total_q) || (PROD_W'({rise, 24'd0}) < prod_q);

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CITY_COUNT; i++) begin
        cur_q[i]  <= CW'(i);
        best_q[i] <= CW'(i);
      end
      cur_total_q  <= '0;
      best_total_q <= '0;
      temp_q       <= '0;
      accepted_q   <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        accepted_q <= 1'b0;
      end
      if (cmd_i.start_set) begin
        cur_q        <= trial_q;
        best_q       <= trial_q;
        cur_total_q  <= acc_q;
        best_total_q <= acc_q;
        temp_q       <= init_temp_q;
      end
      if (cmd_i.decide) begin
        accepted_q <= accept_w;
        if (accept_w) begin
          cur_q       <= trial_q;
          cur_total_q <= acc_q;
        end
      end
      if (cmd_i.best_upd) begin
        if (cur_total_q < best_total_q) begin
          best_q       <= cur_q;
          best_total_q <= cur_total_q;
        end
        temp_q <= prod_q[PROD_W-1:COOL_W];
      end
    end
  end

  // best tour packed three bits per position
  for (genvar g = 0; g < ORDER_POS; g++) begin : g_pack
    if (g < CITY_COUNT) begin : g_pos
      assign order_w[FIELD_CITY_W*g +: FIELD_CITY_W] = FIELD_CITY_W'(best_q[g]);
    end else begin : g_pad
      assign order_w[FIELD_CITY_W*g +: FIELD_CITY_W] = '0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {temp_q <= stop_temp_q, order_w, best_total_q, cur_total_q, accepted_q};
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign stat_o.op       = op_q;
  assign stat_o.hot      = temp_q > stop_temp_q;
  assign stat_o.out_busy = out_valid_q && !m_axis_tready;

  // checks
  `ATSS_ASSERT_NXT(a_start_totals_match, cmd_i.start_set, cur_total_q == best_total_q,
    "start left current and best cost apart")
  `ATSS_ASSERT_NXT(a_best_not_above_cur, cmd_i.best_upd, best_total_q <= cur_total_q,
    "best cost above current cost after update")
  `ATSS_ASSERT_NXT(a_cool_no_rise, cmd_i.best_upd, temp_q <= $past(temp_q),
    "temperature rose while cooling")
  `ATSS_ASSERT_IMP(a_accept_from_decide, $rose(accepted_q), $past(cmd_i.decide),
    "accept flag set outside the decision")

endmodule

@@ tb/annealing_tour_swap_step_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// annealing_tour_swap_step_core_tb
// Self-checking bench for the annealing tour swap step core. Commands are sent
// on the input stream, and a cycle-free predictor of the tour, costs and
// temperature works out each result. Results are checked field by field in
// order. Runs directed corner cases, then random phases with idling,
// stalls, output back-pressure and several register settings.
// ----------------------------------------------------------------------------
module annealing_tour_swap_step_core_tb;
  import atss_pkg::*;

  localparam int unsigned CITIES      = atss_pkg::CITY_COUNT_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 330;
  localparam int unsigned DRAIN_WAIT  = CITIES + 10;
  // command code the block does not use
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  // one command item
  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  from_city;
    logic [2:0]  to_city;
    logic [15:0] distance_value;
    logic [2:0]  swap_first;
    logic [2:0]  swap_second;
    logic [15:0] log_draw;
  } swap_cmd_t;

  localparam int unsigned ITEM_W = $bits(swap_cmd_t);

  // one result item
  typedef struct packed {
    logic                accepted;
    logic [COST_W-1:0]   cur_tour_cost;
    logic [COST_W-1:0]   low_tour_cost;
    logic [ORDER_W-1:0]  best_order;
    logic                finished;
  } tour_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // predictor state
  logic [15:0]       dist_mem [64];
  logic [2:0]        tour_now [CITIES];
  logic [2:0]        tour_best [CITIES];
  logic [COST_W-1:0] cost_now;
  logic [COST_W-1:0] cost_best;
  logic [TEMP_W-1:0] temp_now;
  logic [TEMP_W-1:0] init_temp_reg;
  logic [COOL_W-1:0] cool_reg;
  logic [TEMP_W-1:0] stop_temp_reg;

  tour_result_t pending_results [$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_request = 0;
  int unsigned  hold_left = 0;

  annealing_tour_swap_step_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin : check_results
    tour_result_t want;
    tour_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted      = m_axis_tdata[0];
      got.cur_tour_cost = m_axis_tdata[19:1];
      got.low_tour_cost = m_axis_tdata[38:20];
      got.best_order    = m_axis_tdata[62:39];
      got.finished      = m_axis_tdata[63];
      if (pending_results.size() == 0) begin
        $error("result item with none expected: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
          error_count++;
        end
        if (got.cur_tour_cost !== want.cur_tour_cost) begin
          $error("cur_tour_cost: expected %0d, got %0d", want.cur_tour_cost,
                 got.cur_tour_cost);
          error_count++;
        end
        if (got.low_tour_cost !== want.low_tour_cost) begin
          $error("low_tour_cost: expected %0d, got %0d", want.low_tour_cost,
                 got.low_tour_cost);
          error_count++;
        end
        if (got.best_order !== want.best_order) begin
          $error("best_order: expected %h, got %h", want.best_order, got.best_order);
          error_count++;
        end
        if (got.finished !== want.finished) begin
          $error("finished: expected %0d, got %0d", want.finished, got.finished);
          error_count++;
        end
      end
    end
  end

  // closed-tour length, saturated to the cost width
  function automatic logic [COST_W-1:0] tour_length(input logic [2:0] tour [CITIES]);
    logic [23:0] sum;
    int          i;
    sum = '0;
    for (i = 0; i < CITIES; i++) begin
      sum += dist_mem[{tour[i], tour[(i + 1) % CITIES]}];
    end
    return (sum > COST_MAX) ? COST_MAX : sum[COST_W-1:0];
  endfunction

  // advance the predicted state by one command and form its result
  task automatic predict_anneal_result(input swap_cmd_t c, output tour_result_t r);
    logic [2:0]        trial [CITIES];
    logic [2:0]        held;
    logic [COST_W-1:0] trial_cost;
    logic [63:0]       rise_scaled;
    logic [63:0]       budget;
    logic [47:0]       cooled;
    int unsigned       p;
    int unsigned       q;
    int                i;
    logic              took;
    took = 1'b0;
    if (c.cmd == OP_LOAD) begin
      dist_mem[{c.from_city, c.to_city}] = c.distance_value;
    end else if (c.cmd == OP_START) begin
      for (i = 0; i < CITIES; i++) begin
        tour_now[i]  = 3'(i);
        tour_best[i] = 3'(i);
      end
      cost_now  = tour_length(tour_now);
      cost_best = cost_now;
      temp_now  = init_temp_reg;
    end else if (c.cmd == OP_STEP && temp_now > stop_temp_reg) begin
      p = c.swap_first % CITIES;
      q = c.swap_second % CITIES;
      trial    = tour_now;
      held     = trial[p];
      trial[p] = trial[q];
      trial[q] = held;
      trial_cost = tour_length(trial);
      if (trial_cost <= cost_now) begin
        took = 1'b1;
      end else begin
        // exact compare: rise * 2^24 against Q16.16 temp times Q8.8 draw
        rise_scaled = 64'(trial_cost - cost_now) << 24;
        budget      = 64'(temp_now) * 64'(c.log_draw);
        took        = (rise_scaled < budget);
      end
      if (took) begin
        tour_now = trial;
        cost_now = trial_cost;
      end
      if (cost_now < cost_best) begin
        tour_best = tour_now;
        cost_best = cost_now;
      end
      cooled   = 48'(temp_now) * 48'(cool_reg);
      temp_now = cooled[47:16];
    end
    r.accepted      = took;
    r.cur_tour_cost = cost_now;
    r.low_tour_cost = cost_best;
    r.best_order    = '0;
    for (i = 0; i < CITIES && i < ORDER_POS; i++) begin
      r.best_order[3*i +: 3] = tour_best[i];
    end
    r.finished = (temp_now <= stop_temp_reg);
  endtask

  // item with random filler in the fields the command does not use
  function automatic swap_cmd_t random_item(input logic [1:0] cmd);
    swap_cmd_t c;
    c     = swap_cmd_t'(ITEM_W'({$urandom(), $urandom()}));
    c.cmd = cmd;
    return c;
  endfunction

  function automatic swap_cmd_t load_item(input logic [2:0] row, input logic [2:0] col,
                                          input logic [15:0] dist_val);
    swap_cmd_t c;
    c                = random_item(OP_LOAD);
    c.from_city      = row;
    c.to_city        = col;
    c.distance_value = dist_val;
    return c;
  endfunction

  function automatic swap_cmd_t step_item(input logic [2:0] p, input logic [2:0] q,
                                          input logic [15:0] draw);
    swap_cmd_t c;
    c             = random_item(OP_STEP);
    c.swap_first  = p;
    c.swap_second = q;
    c.log_draw    = draw;
    return c;
  endfunction

  // send one item, record its prediction at the accept edge
  task automatic send_command(input swap_cmd_t c);
    tour_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, c.log_draw, c.swap_second, c.swap_first,
                      c.distance_value, c.to_city, c.from_city};
    s_axis_tuser  <= c.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_anneal_result(c, r);
    pending_results.push_back(r);
  endtask

  // stop sending and wait until every result is back
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_register(input atss_cfg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_INIT_TEMP: init_temp_reg = value;
      CFG_COOLING:   cool_reg = value[COOL_W-1:0];
      CFG_STOP_TEMP: stop_temp_reg = value;
      default: ;
    endcase
  endtask

  task automatic configure_anneal(input logic [31:0] init_t, input logic [15:0] cool,
                                  input logic [31:0] stop_t);
    wait_results_drained();
    write_register(CFG_INIT_TEMP, init_t);
    write_register(CFG_COOLING, {16'd0, cool});
    write_register(CFG_STOP_TEMP, stop_t);
  endtask

  // steps before any start see zero temperature; unused code is ignored
  task automatic test_before_start();
    send_command(step_item(3'd7, 3'd0, 16'hFFFF));
    send_command(random_item(OP_UNUSED));
  endtask

  // every distance entry written once, so no tour reads an unwritten one
  task automatic fill_distance_table();
    int i;
    for (i = 0; i < 64; i++) begin
      send_command(load_item(3'(i / 8), 3'(i % 8), 16'($urandom())));
    end
  endtask

  task automatic test_field_extremes();
    send_command(load_item(3'd7, 3'd0, 16'hFFFF));
    send_command(load_item(3'd0, 3'd0, 16'h0000));
    send_command(random_item(OP_START));
    // equal positions: zero change, accepted
    send_command(step_item(3'd3, 3'd3, 16'($urandom())));
    // zero draw: only a non-rising swap can pass
    send_command(step_item(3'd7, 3'd0, 16'h0000));
    send_command(step_item(3'd0, 3'd7, 16'hFFFF));
    send_command(random_item(OP_UNUSED));
  endtask

  // identity tour on the largest distances
  task automatic test_max_distance();
    int i;
    for (i = 0; i < CITIES; i++) begin
      send_command(load_item(3'(i), 3'((i + 1) % CITIES), 16'hFFFF));
    end
    send_command(random_item(OP_START));
    send_command(step_item(3'd0, 3'd7, 16'h0000));
  endtask

  task automatic test_cooling_extremes();
    // zero cooling: one step drops the temperature to zero
    configure_anneal(32'hFFFF_FFFF, 16'd0, 32'd0);
    send_command(random_item(OP_START));
    send_command(step_item(3'd2, 3'd5, 16'hFFFF));
    send_command(step_item(3'd1, 3'd4, 16'hFFFF));
    // stop level at the top: finished at once
    configure_anneal(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(random_item(OP_START));
    send_command(step_item(3'd1, 3'd6, 16'hFFFF));
    // zero starting temperature
    configure_anneal(32'd0, 16'hFFFF, 32'd0);
    send_command(random_item(OP_START));
    send_command(step_item(3'd4, 3'd5, 16'hFFFF));
  endtask

  // long receiver hold-off while items keep coming
  task automatic test_output_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure_anneal(32'd655360000, 16'd65470, 32'd65536);
    send_command(random_item(OP_START));
    hold_request = 300;
    for (i = 0; i < 6; i++) begin
      send_command(step_item(3'($urandom()), 3'($urandom()), 16'($urandom())));
    end
    wait_results_drained();
  endtask

  task automatic send_random_command();
    swap_cmd_t   c;
    int unsigned pick;
    pick = $urandom_range(99);
    c    = random_item(OP_STEP);
    if (pick < 82) begin
      if ($urandom_range(1)) c.log_draw = 16'($urandom_range(511));
    end else if (pick < 87) begin
      c.cmd = OP_START;
    end else if (pick < 97) begin
      c.cmd = OP_LOAD;
      if ($urandom_range(1)) c.distance_value = 16'($urandom_range(255));
    end else begin
      c.cmd = OP_UNUSED;
    end
    send_command(c);
  endtask

  // random traffic under four idling patterns and register settings
  task automatic test_random_phases();
    int phase;
    int n;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          configure_anneal(32'hFFFF_FFFF, 16'hFFFF, 32'd0);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          configure_anneal(32'd655360000, 16'd65470, 32'd65536);
          send_idle_pct  = 69;
          recv_stall_pct = 0;
        end
        2: begin
          configure_anneal($urandom(), 16'($urandom_range(60000, 65535)),
                           $urandom_range(0, 1 << 20));
          send_idle_pct  = 0;
          recv_stall_pct = 69;
        end
        default: begin
          // cools within a few hundred steps, so cooled steps show up too
          configure_anneal(32'd1 << 20, 16'd65000, 32'd1 << 16);
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase
      send_command(random_item(OP_START));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_random_command();
      end
    end
  endtask

  initial begin
    // predictor follows reset
    foreach (tour_now[i]) begin
      tour_now[i]  = 3'(i);
      tour_best[i] = 3'(i);
    end
    foreach (dist_mem[i]) dist_mem[i] = '0;
    cost_now      = '0;
    cost_best     = '0;
    temp_now      = '0;
    init_temp_reg = 32'd655360000;
    cool_reg      = 16'd65470;
    stop_temp_reg = 32'd65536;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_start();
    fill_distance_table();
    test_field_extremes();
    test_max_distance();
    test_cooling_extremes();
    test_output_backpressure();
    test_random_phases();

    wait_results_drained();
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/atss_pkg.sv
design/atss_ctrl.sv
design/atss_datapath.sv
design/annealing_tour_swap_step_core.sv
tb/annealing_tour_swap_step_core_tb.sv
